>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_n_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
        else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 strict decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    // One input transaction: a UTF-8 byte and its end-of-string mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [15:0] utf16_unit;
        logic        error_flag;
        logic        last_of_string;
    } out_item_t;

    // Kind of decoded operation passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_UNIT,
        OP_PAIR,
        OP_ERROR
    } op_kind_t;

    // Queue entry. For a pair, value holds the code point minus 0x10000.
    typedef struct packed {
        op_kind_t    kind;
        logic [19:0] value;
        logic        last;
    } op_entry_t;

    // Operation queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Length classes of a multi-byte sequence.
    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    // Code point limits.
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] PAIR_BASE = 21'h010000;
    localparam logic [20:0] BMP_MAX   = 21'h00FFFF;

    // Surrogate prefixes.
    localparam logic [15:0] HI_SURR = 16'hD800;
    localparam logic [15:0] LO_SURR = 16'hDC00;

    // Smallest code point allowed for each length class.
    function automatic logic [20:0] class_minimum(input logic [1:0] cls);
        logic [20:0] m;
        case (cls)
            CLASS_TWO:   m = 21'h000080;
            CLASS_THREE: m = 21'h000800;
            CLASS_FOUR:  m = 21'h010000;
            default:     m = 21'h000000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Byte-level UTF-8 decoder: tracks the sequence state and pushes one
// decoded operation per completed code point or error into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u8u16_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire u8u16_pkg::in_item_t item,
    output logic                     q_push,
    output u8u16_pkg::op_entry_t     q_entry
);

    logic [1:0]  remaining_reg,  remaining_next;
    logic [20:0] partial_reg,    partial_next;
    logic [1:0]  class_reg,      class_next;
    logic        discarding_reg, discarding_next;

    // Next-state and operation decode for one accepted byte.
    always_comb
    begin
        logic [7:0]  b;
        logic        eos;
        logic        fail;
        logic        clear;
        logic [20:0] cp_new;
        logic [20:0] cp_sub;
        logic [1:0]  rem_new;

        b      = item.data_byte;
        eos    = item.end_of_string;
        fail   = 1'b0;
        clear  = 1'b0;
        cp_new = {partial_reg[14:0], b[5:0]};
        cp_sub = cp_new - u8u16_pkg::PAIR_BASE;
        rem_new = remaining_reg - 2'd1;

        remaining_next  = remaining_reg;
        partial_next    = partial_reg;
        class_next      = class_reg;
        discarding_next = discarding_reg;
        q_push          = 1'b0;
        q_entry         = '{kind: u8u16_pkg::OP_ERROR, value: '0, last: 1'b1};

        if (accept)
        begin
            if (discarding_reg)
            begin
                // Drop bytes until the end of the failed string.
                if (eos)
                begin
                    discarding_next = 1'b0;
                    clear           = 1'b1;
                end
            end
            else if (remaining_reg == 2'd0)
            begin
                // Lead byte.
                if (!b[7])
                begin
                    q_push  = 1'b1;
                    q_entry = '{kind: u8u16_pkg::OP_UNIT, value: {12'd0, b}, last: eos};
                    clear   = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    partial_next   = {16'd0, b[4:0]};
                    remaining_next = 2'd1;
                    class_next     = u8u16_pkg::CLASS_TWO;
                    fail           = eos;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_next   = {17'd0, b[3:0]};
                    remaining_next = 2'd2;
                    class_next     = u8u16_pkg::CLASS_THREE;
                    fail           = eos;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_next   = {18'd0, b[2:0]};
                    remaining_next = 2'd3;
                    class_next     = u8u16_pkg::CLASS_FOUR;
                    fail           = eos;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                fail = 1'b1;
            end
            else if (rem_new != 2'd0)
            begin
                // Continuation byte with more still expected.
                partial_next   = cp_new;
                remaining_next = rem_new;
                fail           = eos;
            end
            else if ((cp_new < u8u16_pkg::class_minimum(class_reg))
                     || (cp_new > u8u16_pkg::CP_MAX)
                     || ((cp_new >= u8u16_pkg::SURR_LO) && (cp_new <= u8u16_pkg::SURR_HI)))
            begin
                fail = 1'b1;
            end
            else
            begin
                // Completed code point: one unit or a surrogate pair.
                clear  = 1'b1;
                q_push = 1'b1;
                if (cp_new <= u8u16_pkg::BMP_MAX)
                begin
                    q_entry = '{kind: u8u16_pkg::OP_UNIT, value: {4'd0, cp_new[15:0]},
                                last: eos};
                end
                else
                begin
                    q_entry = '{kind: u8u16_pkg::OP_PAIR, value: cp_sub[19:0], last: eos};
                end
            end

            // Any error gives one error result and may start dropping.
            if (fail)
            begin
                clear           = 1'b1;
                discarding_next = !eos;
                q_push          = 1'b1;
                q_entry         = '{kind: u8u16_pkg::OP_ERROR, value: '0, last: 1'b1};
            end

            if (clear)
            begin
                remaining_next = 2'd0;
                partial_next   = '0;
                class_next     = u8u16_pkg::CLASS_NONE;
            end
        end
    end

    // Sequence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg  <= 2'd0;
            partial_reg    <= '0;
            class_reg      <= u8u16_pkg::CLASS_NONE;
            discarding_reg <= 1'b0;
        end
        else
        begin
            remaining_reg  <= remaining_next;
            partial_reg    <= partial_next;
            class_reg      <= class_next;
            discarding_reg <= discarding_next;
        end
    end

    // An open sequence always has a length class and is never being dropped.
    `ASSERT_ALWAYS(a_open_seq_class, clk, rst_n,
        (remaining_reg == 2'd0) || ((class_reg != u8u16_pkg::CLASS_NONE) && !discarding_reg),
        "open sequence without class or while discarding")

    // An error pushed on a byte that does not end the string starts dropping.
    `ASSERT_NEXT(a_error_discards, clk, rst_n,
        q_push && (q_entry.kind == u8u16_pkg::OP_ERROR) && !item.end_of_string,
        discarding_reg && (remaining_reg == 2'd0),
        "error without end of string did not enter discard")

endmodule

`default_nettype wire

>>> design/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Small register queue of decoded operations between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u8u16_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire u8u16_pkg::op_entry_t wr_entry,
    input  wire logic                 rd_en,
    output u8u16_pkg::op_entry_t      rd_entry,
    output logic                      q_full,
    output logic                      q_empty
);

    u8u16_pkg::op_entry_t              slot_reg [u8u16_pkg::QDEPTH];
    logic [u8u16_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [u8u16_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [u8u16_pkg::QCNT_W-1:0]      count_reg,  count_next;
    logic                              do_wr;
    logic                              do_rd;

    // Status and head of queue.
    assign q_full   = (count_reg == u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH));
    assign q_empty  = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // Occupancy stays within depth and matches pointer distance.
    `ASSERT_ALWAYS(a_queue_count, clk, rst_n,
        (count_reg <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH))
        && ((wr_ptr_reg - rd_ptr_reg) == count_reg[u8u16_pkg::QPTR_W-1:0]),
        "queue occupancy inconsistent with pointers")

endmodule

`default_nettype wire

>>> design/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Result stage: expands queued operations into UTF-16 result transactions,
// two for a surrogate pair, and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u8u16_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire u8u16_pkg::op_entry_t q_head,
    output logic                      q_pop,
    input  wire logic                 pop,
    output logic                      empty,
    output u8u16_pkg::out_item_t      result
);

    logic                  out_valid_reg;
    u8u16_pkg::out_item_t  out_reg;
    logic                  pend_reg;
    logic [15:0]           pend_unit_reg;
    logic                  pend_last_reg;
    logic                  load;

    // The output register can take a new transaction when empty or drained.
    assign load   = !out_valid_reg || pop;
    assign q_pop  = load && !pend_reg && !q_empty;
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Output register and low-surrogate holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_reg       <= '0;
            pend_unit_reg <= '0;
            pend_last_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                // Second half of a surrogate pair.
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
                out_reg       <= '{utf16_unit: pend_unit_reg, error_flag: 1'b0,
                                   last_of_string: pend_last_reg};
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                unique case (q_head.kind)
                    u8u16_pkg::OP_UNIT:
                    begin
                        out_reg <= '{utf16_unit: q_head.value[15:0], error_flag: 1'b0,
                                     last_of_string: q_head.last};
                    end
                    u8u16_pkg::OP_PAIR:
                    begin
                        out_reg <= '{utf16_unit: u8u16_pkg::HI_SURR | {6'd0, q_head.value[19:10]},
                                     error_flag: 1'b0, last_of_string: 1'b0};
                        pend_reg      <= 1'b1;
                        pend_unit_reg <= u8u16_pkg::LO_SURR | {6'd0, q_head.value[9:0]};
                        pend_last_reg <= q_head.last;
                    end
                    default:
                    begin
                        out_reg <= '{utf16_unit: 16'd0, error_flag: 1'b1,
                                     last_of_string: 1'b1};
                    end
                endcase
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A pending low surrogate always sits behind a shown high surrogate.
    `ASSERT_ALWAYS(a_pend_behind_high, clk, rst_n,
        !pend_reg || (out_valid_reg && !out_reg.error_flag && !out_reg.last_of_string),
        "pending low surrogate without a high surrogate on the output")

    // A shown result that is not taken holds its value.
    `ASSERT_NEXT(a_hold_result, clk, rst_n,
        out_valid_reg && !pop,
        out_valid_reg && $stable(out_reg),
        "result changed while stalled")

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_strict_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_strict_decoder_core
// Strict UTF-8 to UTF-16 stream decoder with queue-style ports.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle whenever full is low and emits
// UTF-16 units through a registered output with queue-style empty/pop. A
// completed code point in the Basic Multilingual Plane gives one result, a
// supplementary code point gives two results (high surrogate first), and an
// invalid string gives a single error result with a zero unit, after which
// the remaining bytes of that string, through the end-of-string byte, are
// dropped. The front decoder handles one byte per cycle while full is low; the
// result register delivers one unit per cycle while results are popped, so a
// run of supplementary characters (four bytes in, two units out) is limited
// only by the input rate. A four-entry operation queue between the decoder
// and the result register lets each side stall independently. When the queue
// and output are otherwise empty, the first result of a byte is written into
// a queue slot and then loaded into the output register, where it is on the
// result ports and can be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_strict_decoder_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire u8u16_pkg::in_item_t  item,
    output logic                      empty,
    input  wire logic                 pop,
    output u8u16_pkg::out_item_t      result
);

    logic                  accept;
    logic                  q_push;
    u8u16_pkg::op_entry_t  q_wr_entry;
    u8u16_pkg::op_entry_t  q_head;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;

    // Input handshake: a byte is taken while the operation queue has room.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Byte decoder.
    u8u16_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .q_push  (q_push),
        .q_entry (q_wr_entry)
    );

    // Operation queue between decoder and result stage.
    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .rd_en    (q_pop),
        .rd_entry (q_head),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // Result expansion and output register.
    u8u16_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire
